// File: design/sql_keyword_quote_screen_defines.svh
// Assertion macros for the SQL keyword and quote screen.
`ifndef SQL_KEYWORD_QUOTE_SCREEN_DEFINES_SVH
`define SQL_KEYWORD_QUOTE_SCREEN_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SKQS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SKQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/skqs_pkg.sv
// Package: keyword table, verdict codes and byte helpers for the SQL screen.
`timescale 1ns / 1ps
package skqs_pkg;

  localparam int unsigned MATCH_WINDOW_DEF = 12;
  localparam int unsigned KW_COUNT = 13;
  localparam int unsigned KW_MAX   = 12;
  localparam int unsigned KW_BITS  = 8 * KW_MAX;

  localparam logic [7:0] QUOTE_CHAR = 8'h27;

  typedef enum logic [1:0] {
    VERDICT_OK      = 2'd0,
    VERDICT_KEYWORD = 2'd1,
    VERDICT_QUOTE   = 2'd2
  } verdict_e;

  // Keywords right-aligned: byte 0 holds the last character.
  localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
    KW_BITS'("DROP"),
    KW_BITS'("TRUNCATE"),
    KW_BITS'("ALTER"),
    KW_BITS'("DELETE FROM"),
    KW_BITS'("--"),
    KW_BITS'("/*"),
    KW_BITS'("*/"),
    KW_BITS'("; --"),
    KW_BITS'("UNION SELECT"),
    KW_BITS'("OR 1=1"),
    KW_BITS'("OR '1'='1"),
    KW_BITS'("EXEC("),
    KW_BITS'("EXECUTE(")
  };

  localparam int unsigned KW_LEN [KW_COUNT] = '{4, 8, 5, 11, 2, 2, 2, 4, 12, 6, 9, 5, 8};

  // Fold ASCII a..z to upper case; everything else passes as is.
  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h61:8'h7a]}) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

  // Tail byte t is the byte t positions before the newest one (t = 0 newest).
  function automatic logic kw_hit(input logic [KW_BITS-1:0] tail);
    logic hit;
    logic same;
    hit = 1'b0;
    for (int unsigned k = 0; k < KW_COUNT; k++) begin
      same = 1'b1;
      for (int unsigned t = 0; t < KW_MAX; t++) begin
        if (t < KW_LEN[k] && tail[8*t +: 8] != KW_TEXT[k][8*t +: 8]) begin
          same = 1'b0;
        end
      end
      hit = hit | same;
    end
    return hit;
  endfunction

endpackage

// File: design/sql_keyword_quote_screen.sv
// Top level: byte-serial SQL keyword and single-quote parity screen.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in      | sink      | in_valid_i / in_stall_o  | char_byte_i[7:0], last_byte_i
//   out     | source    | out_valid_o / out_stall_i| verdict_o[1:0]
//
// One byte a cycle while no final byte waits on a stalled verdict. Each byte is
// held in the input register; the keyword compare and state update run between
// that register and the result register, which takes the verdict of a final byte.
// Reset clears the history window, the keyword flag and the quote parity.
// A stalled verdict holds the output register; non-final bytes keep flowing,
// and only a final byte waits behind a verdict that has not been taken.
`timescale 1ns / 1ps
`include "sql_keyword_quote_screen_defines.svh"
module sql_keyword_quote_screen
  import skqs_pkg::*;
#(
  parameter int unsigned MatchWindow = MATCH_WINDOW_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] verdict_o
);

  // History bytes held behind the newest one.
  localparam int unsigned HistDepth = MatchWindow - 1;

  // Input register: folded byte, raw quote flag, end-of-string flag.
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_quote_q;
  logic       s1_last_q;

  // Per-string state.
  logic [7:0] hist_q [HistDepth];
  logic       seen_q;
  logic       odd_q;

  // Result register.
  logic     out_valid_q;
  verdict_e verdict_q;

  logic               out_free;
  logic               s1_adv;
  logic               in_take;
  logic [KW_BITS-1:0] tail;
  logic               hit;
  logic               seen_now;
  logic               odd_now;
  verdict_e           verdict_d;

  // A final byte needs room in the result register; other bytes never wait.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!s1_last_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  // Build the compare tail: newest byte first, then the most recent history.
  always_comb begin
    tail[7:0] = s1_byte_q;
    for (int unsigned t = 1; t < KW_MAX; t++) begin
      tail[8*t +: 8] = hist_q[HistDepth - t];
    end
  end

  assign hit      = kw_hit(tail);
  assign seen_now = seen_q || hit;
  assign odd_now  = odd_q ^ s1_quote_q;

  // Keyword match wins over odd quote parity.
  always_comb begin
    if (seen_now) begin
      verdict_d = VERDICT_KEYWORD;
    end else if (odd_now) begin
      verdict_d = VERDICT_QUOTE;
    end else begin
      verdict_d = VERDICT_OK;
    end
  end

  // Capture the incoming item; fold case here so the compare sees upper case.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_byte_q  <= '0;
      s1_quote_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
        s1_byte_q  <= fold_upper(char_byte_i);
        s1_quote_q <= (char_byte_i == QUOTE_CHAR);
        s1_last_q  <= last_byte_i;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Advance the window and sticky flags; drop everything after a final byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned j = 0; j < HistDepth; j++) begin
        hist_q[j] <= '0;
      end
      seen_q <= 1'b0;
      odd_q  <= 1'b0;
    end else if (s1_adv) begin
      if (s1_last_q) begin
        for (int unsigned j = 0; j < HistDepth; j++) begin
          hist_q[j] <= '0;
        end
        seen_q <= 1'b0;
        odd_q  <= 1'b0;
      end else begin
        for (int unsigned j = 0; j + 1 < HistDepth; j++) begin
          hist_q[j] <= hist_q[j + 1];
        end
        hist_q[HistDepth - 1] <= s1_byte_q;
        seen_q <= seen_now;
        odd_q  <= odd_now;
      end
    end
  end

  // Load a verdict on a final byte; hold it until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      verdict_q   <= VERDICT_OK;
    end else begin
      if (s1_adv && s1_last_q) begin
        out_valid_q <= 1'b1;
        verdict_q   <= verdict_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

  // A final byte always lands a verdict in the next cycle.
  `SKQS_ASSERT_NEXT(a_last_gives_verdict, s1_adv && s1_last_q, out_valid_q, "final item lost its verdict")
  // String state is cleared once a final byte goes through.
  `SKQS_ASSERT_NEXT(a_clear_after_last, s1_adv && s1_last_q, !seen_q && !odd_q && hist_q[HistDepth - 1] == 8'h00, "state not cleared after final item")
  // A keyword hit on a middle byte sticks.
  `SKQS_ASSERT_NEXT(a_hit_sticks, s1_adv && !s1_last_q && hit, seen_q, "keyword hit not recorded")
  // A final byte never overwrites a verdict that is still stalled.
  `SKQS_ASSERT_NOW(a_no_overwrite, out_valid_q && out_stall_i && s1_valid_q && s1_last_q, !s1_adv, "verdict overwritten while stalled")

endmodule
